// ===== hw/rtl/rsdm_pkg.sv =====
// Shared constants and types of the star/dot pattern matcher.
`default_nettype none

package rsdm_pkg;

	// Largest pattern the block can be built for, and the default build
	localparam int PATTERN_MAX_DEF = 16;

	// Fixed field widths of the configuration port
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 2;
	localparam int LEN_FIELD_W = 5;

	// Special characters of the pattern language
	localparam logic [7:0] CHAR_STAR = 8'h2A;
	localparam logic [7:0] CHAR_DOT  = 8'h2E;
	localparam logic [7:0] CHAR_NUL  = 8'h00;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PAT_LOW  = 2'd0,
		CFG_PAT_HIGH = 2'd1,
		CFG_PAT_LEN  = 2'd2
	} cfg_reg_t;

	// Pattern decode sequencer states
	typedef enum logic [1:0] {
		DEC_IDLE   = 2'd0,
		DEC_WALK   = 2'd1,
		DEC_SETTLE = 2'd2
	} dec_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/regex_star_dot_matcher.sv =====
// Top level of the whole-string matcher for patterns with '.' and '*'.
//
// Text streams in on the input channel, one item per transfer: text_byte with
// byte_present set carries a character, byte_present clear carries none, and
// end_of_text marks the last item of a string. On each last item one result
// transfer on the output channel reports in matched whether the whole string
// matched the whole pattern; other items give no result.
// A last item passes the input register and then the result register, which holds its result.
// Throughput: one item per cycle while the tokenizer is idle and no held result blocks
// a last item; the active-position update is one register to register step through token compare and star closure.
// The pattern is set over the configuration channel (index 0: characters 0-7,
// 1: characters 8-15, 2: length), always ready. Each write to one of these
// restarts the current string and runs the pattern tokenizer, one position a
// cycle: in_ready is low while the tokenizer walks and settles after the write.
// Reset clears the pattern to empty; no tokenizer pass is needed after reset.
// When the receiver stalls, the result register holds and the input register
// keeps taking items until a second last item waits behind the held result.
`default_nettype none

module regex_star_dot_matcher #(
	parameter int PATTERN_MAX = rsdm_pkg::PATTERN_MAX_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [7:0]                        text_byte,
	input  wire logic                              byte_present,
	input  wire logic                              end_of_text,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   matched,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [rsdm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [rsdm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);

	logic [PATTERN_MAX-1:0][7:0] pat_chars;
	logic [LEN_W-1:0]            pat_len;
	logic [PATTERN_MAX-1:0]      star_mask;
	logic                        dec_busy;

	assign cfg_ready = 1'b1;

	rsdm_decode #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pat_chars(pat_chars),
		.pat_len  (pat_len),
		.star_mask(star_mask),
		.busy     (dec_busy)
	);

	rsdm_core #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.pat_chars   (pat_chars),
		.pat_len     (pat_len),
		.star_mask   (star_mask),
		.busy        (dec_busy),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.text_byte   (text_byte),
		.byte_present(byte_present),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.matched     (matched)
	);

	// No text is taken while the tokenizer runs
	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		dec_busy |-> !in_ready)
		else $error("input accepted while pattern decode is running");

	// A pattern write always starts a decode pass
	a_write_starts_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && (cfg_index == rsdm_pkg::CFG_PAT_LOW
		 || cfg_index == rsdm_pkg::CFG_PAT_HIGH || cfg_index == rsdm_pkg::CFG_PAT_LEN))
		|=> dec_busy && !in_ready)
		else $error("pattern write did not start a decode pass");

endmodule

`default_nettype wire

// ===== hw/rtl/rsdm_decode.sv =====
// Configuration registers and the sequential pattern tokenizer.
`default_nettype none

module rsdm_decode #(
	parameter int PATTERN_MAX = rsdm_pkg::PATTERN_MAX_DEF,
	localparam int LEN_W = $clog2(PATTERN_MAX + 1),
	localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr,
	input  wire logic [rsdm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [rsdm_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic      [PATTERN_MAX-1:0][7:0]        pat_chars,
	output logic      [LEN_W-1:0]                   pat_len,
	output logic      [PATTERN_MAX-1:0]             star_mask,
	output logic                                    busy
);

	logic [rsdm_pkg::CFG_DATA_W-1:0]  pat_low_q;
	logic [rsdm_pkg::CFG_DATA_W-1:0]  pat_high_q;
	logic [rsdm_pkg::LEN_FIELD_W-1:0] len_cfg_q;
	logic [2*rsdm_pkg::CFG_DATA_W-1:0] pat_all;

	rsdm_pkg::dec_state_t state_q, state_nx;

	logic [IDX_W-1:0]       idx_q;
	logic                   open_q;
	logic                   start_q;
	logic [LEN_W-1:0]       len_q;
	logic [PATTERN_MAX-1:0] star_q;

	logic                              restart;
	logic                              walk;
	logic                              idx_last;
	logic [rsdm_pkg::LEN_FIELD_W-1:0]  lim;
	logic [rsdm_pkg::LEN_FIELD_W-1:0]  idx_ext;
	logic [rsdm_pkg::LEN_FIELD_W-1:0]  idx_inc;
	logic [IDX_W-1:0]                  idx_nx;
	logic [7:0]                        cur_char;
	logic [7:0]                        nxt_char;
	logic                              cur_used;
	logic                              nxt_used;
	logic                              starred;

	// Restart the walk on any write to a known register
	always_comb begin
		case (rsdm_pkg::cfg_reg_t'(cfg_index))
			rsdm_pkg::CFG_PAT_LOW,
			rsdm_pkg::CFG_PAT_HIGH,
			rsdm_pkg::CFG_PAT_LEN: restart = cfg_wr;
			default:               restart = 1'b0;
		endcase
	end

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			len_cfg_q  <= '0;
		end else if (cfg_wr) begin
			case (rsdm_pkg::cfg_reg_t'(cfg_index))
				rsdm_pkg::CFG_PAT_LOW:  pat_low_q  <= cfg_data;
				rsdm_pkg::CFG_PAT_HIGH: pat_high_q <= cfg_data;
				rsdm_pkg::CFG_PAT_LEN:  len_cfg_q  <= cfg_data[rsdm_pkg::LEN_FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	// Slice the pattern into characters
	assign pat_all = {pat_high_q, pat_low_q};
	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			pat_chars[i] = pat_all[8*i +: 8];
		end
	end

	// Sequencer: walk one position per cycle, then settle before going idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsdm_pkg::DEC_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign idx_last = (idx_q == IDX_W'(PATTERN_MAX - 1));

	always_comb begin
		state_nx = state_q;
		walk     = 1'b0;
		busy     = 1'b1;
		case (state_q)
			rsdm_pkg::DEC_IDLE: begin
				busy = 1'b0;
			end
			rsdm_pkg::DEC_WALK: begin
				walk = 1'b1;
				if (idx_last) begin
					state_nx = rsdm_pkg::DEC_SETTLE;
				end
			end
			rsdm_pkg::DEC_SETTLE: begin
				state_nx = rsdm_pkg::DEC_IDLE;
			end
			default: begin
				state_nx = rsdm_pkg::DEC_IDLE;
			end
		endcase
		if (restart) begin
			state_nx = rsdm_pkg::DEC_WALK;
			walk     = 1'b0;
		end
	end

	// Tokenize at the current position: a token start followed by '*' is starred
	assign lim      = (len_cfg_q > rsdm_pkg::LEN_FIELD_W'(PATTERN_MAX))
	                  ? rsdm_pkg::LEN_FIELD_W'(PATTERN_MAX) : len_cfg_q;
	assign idx_ext  = rsdm_pkg::LEN_FIELD_W'(idx_q);
	assign idx_inc  = idx_ext + rsdm_pkg::LEN_FIELD_W'(1);
	assign idx_nx   = idx_q + IDX_W'(1);
	assign cur_char = pat_chars[idx_q];
	assign nxt_char = idx_last ? rsdm_pkg::CHAR_NUL : pat_chars[idx_nx];
	assign cur_used = open_q && (idx_ext < lim) && (cur_char != rsdm_pkg::CHAR_NUL);
	assign nxt_used = cur_used && !idx_last && (idx_inc < lim)
	                  && (nxt_char != rsdm_pkg::CHAR_NUL);
	assign starred  = cur_used && start_q && nxt_used && (nxt_char == rsdm_pkg::CHAR_STAR);

	// Accumulate effective length and starred-token mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			open_q  <= 1'b1;
			start_q <= 1'b1;
			len_q   <= '0;
			star_q  <= '0;
		end else if (restart) begin
			idx_q   <= '0;
			open_q  <= 1'b1;
			start_q <= 1'b1;
			len_q   <= '0;
			star_q  <= '0;
		end else if (walk) begin
			idx_q         <= idx_nx;
			open_q        <= cur_used;
			start_q       <= !starred;
			star_q[idx_q] <= starred;
			if (cur_used) begin
				len_q <= LEN_W'(idx_inc);
			end
		end
	end

	assign pat_len   = len_q;
	assign star_mask = star_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rsdm_core.sv =====
// Input register, active-position update and result register of the matcher.
`default_nettype none

module rsdm_core #(
	parameter int PATTERN_MAX = rsdm_pkg::PATTERN_MAX_DEF,
	localparam int LEN_W = $clog2(PATTERN_MAX + 1),
	localparam int ACT_W = PATTERN_MAX + 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [PATTERN_MAX-1:0][7:0] pat_chars,
	input  wire logic [LEN_W-1:0]            pat_len,
	input  wire logic [PATTERN_MAX-1:0]      star_mask,
	input  wire logic                        busy,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [7:0]                  text_byte,
	input  wire logic                        byte_present,
	input  wire logic                        end_of_text,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             matched
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       present_s1;
	logic       last_s1;

	logic [ACT_W-1:0] active_q;
	logic             out_valid_q;
	logic             matched_q;

	logic             advance;
	logic [ACT_W-1:0] start_set;
	logic [ACT_W-1:0] shift_set;
	logic [ACT_W-1:0] step_set;
	logic [ACT_W-1:0] final_set;

	// Add positions reached by skipping starred tokens
	function automatic logic [ACT_W-1:0] close_set(
		input logic [ACT_W-1:0]       s,
		input logic [PATTERN_MAX-1:0] star
	);
		logic [ACT_W-1:0] c;
		c = s;
		for (int p = 0; p < PATTERN_MAX - 1; p++) begin
			if (c[p] && star[p]) begin
				c[p+2] = 1'b1;
			end
		end
		return c;
	endfunction

	assign start_set = close_set(ACT_W'(1), star_mask);

	// Move every active position across a matching token; a starred token keeps its position
	always_comb begin
		shift_set = '0;
		for (int p = 0; p < PATTERN_MAX; p++) begin
			if (active_q[p] && (LEN_W'(p) < pat_len) && (byte_s1 != rsdm_pkg::CHAR_NUL)
			    && ((pat_chars[p] == byte_s1) || (pat_chars[p] == rsdm_pkg::CHAR_DOT))) begin
				if (star_mask[p]) begin
					shift_set[p] = 1'b1;
				end else begin
					shift_set[p+1] = 1'b1;
				end
			end
		end
	end

	assign step_set  = close_set(shift_set, star_mask);
	assign final_set = present_s1 ? step_set : active_q;

	// Stage advances unless a result has nowhere to go
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !busy && (!valid_s1 || advance);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1    <= text_byte;
			present_s1 <= byte_present;
			last_s1    <= end_of_text;
		end
	end

	// Active position set: reload on pattern change and after each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACT_W'(1);
		end else if (busy) begin
			active_q <= start_set;
		end else if (advance) begin
			active_q <= last_s1 ? start_set : final_set;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			matched_q <= final_set[pat_len];
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;

endmodule

`default_nettype wire
